### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hdl/ycc2rgb_pkg.sv
`default_nettype none

package ycc2rgb_pkg;

	typedef enum logic {
		STD_BT601 = 1'b0,
		STD_BT709 = 1'b1
	} color_std_t;

	// APB map: one 32-bit register per word.
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic REG_COLOR_STANDARD = 1'b0;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] red_diff;
		logic [7:0] blue_diff;
		logic [7:0] alpha_in;
	} ycc_pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgb_pixel_t;

	// Luma weights of each standard, as integer ratios over that standard's own denominator.
	localparam longint unsigned D_601  = 1000;
	localparam longint unsigned KR_601 = 299;
	localparam longint unsigned KB_601 = 114;
	localparam longint unsigned KG_601 = 587;
	localparam longint unsigned D_709  = 10000;
	localparam longint unsigned KR_709 = 2125;
	localparam longint unsigned KB_709 = 721;
	localparam longint unsigned KG_709 = 7154;

endpackage

`default_nettype wire

### hdl/ycc2rgb_ycc_if.sv
`default_nettype none

interface ycc2rgb_ycc_if import ycc2rgb_pkg::*; ();
	logic       valid;
	logic       ready;
	ycc_pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/ycc2rgb_rgb_if.sv
`default_nettype none

interface ycc2rgb_rgb_if import ycc2rgb_pkg::*; ();
	logic       valid;
	logic       ready;
	rgb_pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/ycbcr_to_rgb_converter.sv
`default_nettype none
`include "assert_macros.svh"

// Full-range YCbCr to RGB converter. Each beat on ycc carries Y, Cr, Cb and
// alpha; each beat on rgb carries R, G, B saturated to 0..255 and the alpha
// unchanged. Chroma is taken relative to 128 and luma is not scaled. The
// color_standard register (APB address 0, bit 0) picks BT.601 (0) or BT.709
// (1) coefficients; write it only while no pixel is in flight. The datapath
// is a three-stage pipeline (register inputs, multiply, sum and saturate):
// it takes one pixel per clock while the output is not stalled, and each
// stage holds its pixel while the next one is full and cannot move on, so
// bubbles are squeezed out during a stall.
module ycbcr_to_rgb_converter import ycc2rgb_pkg::*; #(
	parameter int unsigned COEF_FRAC_BITS = 14
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [APB_ADDR_W-1:0]        paddr,
	input  wire [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]       prdata,
	output logic                        pready,
	ycc2rgb_ycc_if.sink                 ycc,
	ycc2rgb_rgb_if.source               rgb
);

	localparam int unsigned F  = COEF_FRAC_BITS;
	localparam int unsigned CW = F + 2;   // unsigned Q2.F coefficient
	localparam int unsigned PW = CW + 9;  // signed coefficient times signed chroma
	localparam int unsigned YW = F + 8;   // luma scaled up by 2^F
	localparam int unsigned SW = F + 12;  // channel sum before the shift
	localparam longint unsigned ONE = 64'd1 << F;

	localparam logic [CW-1:0] CR_R_601 =
		CW'((2 * (D_601 - KR_601) * ONE + D_601 / 2) / D_601);
	localparam logic [CW-1:0] CB_B_601 =
		CW'((2 * (D_601 - KB_601) * ONE + D_601 / 2) / D_601);
	localparam logic [CW-1:0] CB_G_601 =
		CW'((2 * (D_601 - KB_601) * KB_601 * ONE + (D_601 * KG_601) / 2) / (D_601 * KG_601));
	localparam logic [CW-1:0] CR_G_601 =
		CW'((2 * (D_601 - KR_601) * KR_601 * ONE + (D_601 * KG_601) / 2) / (D_601 * KG_601));
	localparam logic [CW-1:0] CR_R_709 =
		CW'((2 * (D_709 - KR_709) * ONE + D_709 / 2) / D_709);
	localparam logic [CW-1:0] CB_B_709 =
		CW'((2 * (D_709 - KB_709) * ONE + D_709 / 2) / D_709);
	localparam logic [CW-1:0] CB_G_709 =
		CW'((2 * (D_709 - KB_709) * KB_709 * ONE + (D_709 * KG_709) / 2) / (D_709 * KG_709));
	localparam logic [CW-1:0] CR_G_709 =
		CW'((2 * (D_709 - KR_709) * KR_709 * ONE + (D_709 * KG_709) / 2) / (D_709 * KG_709));

	// Configuration register
	color_std_t color_standard_q;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_standard_q <= STD_BT601;
		end else if (cfg_write && paddr[2] == REG_COLOR_STANDARD) begin
			color_standard_q <= color_std_t'(pwdata[0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_COLOR_STANDARD) begin
			prdata[0] = color_standard_q;
		end
	end

	// Coefficient selection
	logic [CW-1:0] coef_cr_r, coef_cb_b, coef_cb_g, coef_cr_g;

	always_comb begin
		unique case (color_standard_q)
			STD_BT709: begin
				coef_cr_r = CR_R_709;
				coef_cb_b = CB_B_709;
				coef_cb_g = CB_G_709;
				coef_cr_g = CR_G_709;
			end
			default: begin
				coef_cr_r = CR_R_601;
				coef_cb_b = CB_B_601;
				coef_cb_g = CB_G_601;
				coef_cr_g = CR_G_601;
			end
		endcase
	end

	// Stage advance: a stage loads when it is empty or the next one moves on.
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3      = !valid_s3 || rgb.ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign ycc.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= ycc.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: input register, chroma recentred on zero by flipping its top bit.
	logic [7:0]        luma_s1;
	logic signed [7:0] cr_s1, cb_s1;
	logic [7:0]        alpha_s1;

	always_ff @(posedge clk) begin
		if (adv1 && ycc.valid) begin
			luma_s1  <= ycc.data.luma;
			cr_s1    <= {~ycc.data.red_diff[7], ycc.data.red_diff[6:0]};
			cb_s1    <= {~ycc.data.blue_diff[7], ycc.data.blue_diff[6:0]};
			alpha_s1 <= ycc.data.alpha_in;
		end
	end

	// Stage 2: products
	logic [YW-1:0]        ys_s2;
	logic signed [PW-1:0] p_cr_r_s2, p_cb_b_s2, p_cb_g_s2, p_cr_g_s2;
	logic [7:0]           alpha_s2;

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			ys_s2     <= {luma_s1, F'(0)};
			p_cr_r_s2 <= $signed({1'b0, coef_cr_r}) * cr_s1;
			p_cb_b_s2 <= $signed({1'b0, coef_cb_b}) * cb_s1;
			p_cb_g_s2 <= $signed({1'b0, coef_cb_g}) * cb_s1;
			p_cr_g_s2 <= $signed({1'b0, coef_cr_g}) * cr_s1;
			alpha_s2  <= alpha_s1;
		end
	end

	// Stage 3: sums, arithmetic shift and saturation
	function automatic logic [7:0] shift_sat(input logic signed [SW-1:0] sum);
		logic [SW-F-1:0] whole;
		whole = sum[SW-1:F];
		if (whole[SW-F-1]) begin
			return 8'd0;
		end else if (|whole[SW-F-2:8]) begin
			return 8'd255;
		end else begin
			return whole[7:0];
		end
	endfunction

	logic signed [SW-1:0] ys_ext, sum_r, sum_g, sum_b;
	rgb_pixel_t           pix_s3;

	assign ys_ext = $signed({(SW - YW)'(0), ys_s2});
	assign sum_r  = ys_ext + SW'(p_cr_r_s2);
	assign sum_g  = ys_ext - SW'(p_cb_g_s2) - SW'(p_cr_g_s2);
	assign sum_b  = ys_ext + SW'(p_cb_b_s2);

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			pix_s3.red       <= shift_sat(sum_r);
			pix_s3.green     <= shift_sat(sum_g);
			pix_s3.blue      <= shift_sat(sum_b);
			pix_s3.alpha_out <= alpha_s2;
		end
	end

	assign rgb.valid = valid_s3;
	assign rgb.data  = pix_s3;

	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, ycc.valid && ycc.ready, valid_s1)
	`ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !adv2,
		valid_s1 && $stable(alpha_s1) && $stable(luma_s1))
	`ASSERT_NEXT(a_s2_holds_on_stall, clk, arst_n, valid_s2 && !adv3,
		valid_s2 && $stable(alpha_s2) && $stable(ys_s2))
	`ASSERT_IMPLIES(a_full_pipe_backpressure, clk, arst_n,
		valid_s1 && valid_s2 && valid_s3 && !rgb.ready, !ycc.ready)

endmodule

`default_nettype wire
